FILE: rtl/positional_list_buffer_macros.svh
// Assertion macros shared by the list buffer RTL
`ifndef POSITIONAL_LIST_BUFFER_MACROS_SVH
`define POSITIONAL_LIST_BUFFER_MACROS_SVH

// Same-cycle implication, disabled in reset
`define PLB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define PLB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/plb_pkg.sv
// Types and constants for the positional list buffer
package plb_pkg;

  localparam int ACT_W  = 3;
  localparam int POS_W  = 7;
  localparam int VAL_W  = 32;
  localparam int ST_W   = 2;
  localparam int CNT_W  = 7;

  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND   = 3'd0,
    ACT_REMOVE   = 3'd1,
    ACT_INSERT   = 3'd2,
    ACT_ERASE    = 3'd3,
    ACT_ERASE_BT = 3'd4,
    ACT_READ     = 3'd5,
    ACT_CLEAR    = 3'd6
  } act_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADIDX = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // What every cell of the row does on a given cycle
  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_UP   = 2'd1,
    OP_DOWN = 2'd2
  } cell_op_t;

endpackage

FILE: rtl/plb_if.sv
// Handshake channels of the list buffer: action items in, result items out
interface plb_in_if
  import plb_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [ACT_W-1:0]         action;
  logic [POS_W-1:0]         position;
  logic [POS_W-1:0]         position_two;
  logic signed [VAL_W-1:0]  value;

  modport source (output valid, action, position, position_two, value, input ready);
  modport sink   (input valid, action, position, position_two, value, output ready);
endinterface

interface plb_out_if
  import plb_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [ST_W-1:0]          status;
  logic signed [VAL_W-1:0]  read_value;
  logic [CNT_W-1:0]         count;
  logic                     is_empty;
  logic signed [VAL_W-1:0]  first_value;
  logic signed [VAL_W-1:0]  last_value;

  modport source (output valid, status, read_value, count, is_empty, first_value,
                  last_value, input ready);
  modport sink   (input valid, status, read_value, count, is_empty, first_value,
                  last_value, output ready);
endinterface

FILE: rtl/plb_cell.sv
// One list position: holds a word, loads the new word or takes a neighbour's
module plb_cell
  import plb_pkg::*;
#(
  parameter int IDX        = 0,
  parameter int DATA_WIDTH = 32,
  parameter int IW         = 7
) (
  input  logic                  clk,
  input  cell_op_t              op,
  input  logic [IW-1:0]         pos,
  input  logic [DATA_WIDTH-1:0] wr_data,
  input  logic [DATA_WIDTH-1:0] left_q,
  input  logic [DATA_WIDTH-1:0] right_q,
  output logic [DATA_WIDTH-1:0] q
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [DATA_WIDTH-1:0] q_r;
  logic [DATA_WIDTH-1:0] q_nxt;

  always_comb begin
    q_nxt = q_r;
    case (op)
      OP_UP: begin
        if (MY_IDX == pos) begin
          q_nxt = wr_data;
        end else if (MY_IDX > pos) begin
          q_nxt = left_q;
        end
      end
      OP_DOWN: begin
        if (MY_IDX >= pos) begin
          q_nxt = right_q;
        end
      end
      default: q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

FILE: rtl/positional_list_buffer.sv
// Positional list buffer: packed list of words in a row of shifting cells
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+---------------------------------------------
//   in_ch    | in  | valid / ready | action, position, position_two, value
//   out_ch   | out | valid / ready | status, read_value, count, is_empty,
//            |     |               | first_value, last_value
//
// Every action but an erase-between with entries strictly between its
// bounds updates the cells at the accepting edge; the result is then
// registered in S_REPORT once the output register is free. Such an
// erase-between first passes through S_SHIFT, which moves the row down one
// place per cycle. One item is worked on at a time; the next is taken while a
// result waits in the output register. Reset empties the list; the cell words are not cleared.
module positional_list_buffer
  import plb_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic   clk,
  input  logic   rst_n,
  plb_in_if.sink    in_ch,
  plb_out_if.source out_ch
);

  `include "positional_list_buffer_macros.svh"

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int IW   = (CW > POS_W) ? CW : POS_W;
  localparam int AW   = $clog2(DEPTH);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_SHIFT, S_REPORT} state_t;

  function automatic logic signed [VAL_W-1:0] ext_out(input logic signed [DATA_WIDTH-1:0] w);
    logic signed [63:0] t;
    t = 64'(w);
    return t[VAL_W-1:0];
  endfunction

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [IW-1:0]   start_r, start_nxt;
  logic [IW-1:0]   left_r, left_nxt;
  logic [AW-1:0]   rd_idx_r, rd_idx_nxt;
  logic            rd_ok_r, rd_ok_nxt;
  status_t         st_r, st_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [ST_W-1:0] out_status_r, out_status_nxt;
  logic signed [VAL_W-1:0] out_rd_r, out_rd_nxt;
  logic [CNT_W-1:0] out_count_r, out_count_nxt;
  logic            out_empty_r, out_empty_nxt;
  logic signed [VAL_W-1:0] out_first_r, out_first_nxt;
  logic signed [VAL_W-1:0] out_last_r, out_last_nxt;

  cell_op_t        op;
  logic [IW-1:0]   op_pos;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [DATA_WIDTH-1:0] cell_q [DEPTH];

  logic            in_acc;
  logic [IW-1:0]   cnt_x, pos_x, pos2_x, pos_eff, lo, hi, gap;
  logic signed [63:0] val64;
  logic            full;
  act_t            act;

  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign act         = act_t'(in_ch.action);
  assign cnt_x       = IW'(count_r);
  assign pos_x       = IW'(in_ch.position);
  assign pos2_x      = IW'(in_ch.position_two);
  assign full        = (count_r == FULL_CNT);
  assign val64       = 64'(in_ch.value);
  assign wr_data     = val64[DATA_WIDTH-1:0];
  assign pos_eff     = (count_r == '0) ? '0 : pos_x;
  assign lo          = (pos_x < pos2_x) ? pos_x : pos2_x;
  assign hi          = (pos_x < pos2_x) ? pos2_x : pos_x;
  assign gap         = hi - lo;

  // Row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    plb_cell #(
      .IDX        (i),
      .DATA_WIDTH (DATA_WIDTH),
      .IW         (IW)
    ) u_cell (
      .clk     (clk),
      .op      (op),
      .pos     (op_pos),
      .wr_data (wr_data),
      .left_q  (cell_q[(i == 0) ? i : i - 1]),
      .right_q (cell_q[(i == DEPTH - 1) ? i : i + 1]),
      .q       (cell_q[i])
    );
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    start_nxt      = start_r;
    left_nxt       = left_r;
    rd_idx_nxt     = rd_idx_r;
    rd_ok_nxt      = rd_ok_r;
    st_nxt         = st_r;
    op             = OP_HOLD;
    op_pos         = '0;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_rd_nxt     = out_rd_r;
    out_count_nxt  = out_count_r;
    out_empty_nxt  = out_empty_r;
    out_first_nxt  = out_first_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          st_nxt     = ST_OK;
          rd_ok_nxt  = 1'b0;
          rd_idx_nxt = AW'(pos_x);
          state_nxt  = S_REPORT;
          unique case (act)
            ACT_APPEND: begin
              if (full) begin
                st_nxt = ST_FULL;
              end else begin
                op        = OP_UP;
                op_pos    = cnt_x;
                count_nxt = count_r + CW'(1);
              end
            end
            ACT_REMOVE: begin
              if (count_r == '0) st_nxt = ST_EMPTY;
              else count_nxt = count_r - CW'(1);
            end
            ACT_INSERT: begin
              if (pos_eff > cnt_x) begin
                st_nxt = ST_BADIDX;
              end else if (full) begin
                st_nxt = ST_FULL;
              end else begin
                op        = OP_UP;
                op_pos    = pos_eff;
                count_nxt = count_r + CW'(1);
              end
            end
            ACT_ERASE: begin
              if (pos_x >= cnt_x) begin
                st_nxt = ST_BADIDX;
              end else begin
                op        = OP_DOWN;
                op_pos    = pos_x;
                count_nxt = count_r - CW'(1);
              end
            end
            ACT_ERASE_BT: begin
              if (pos_x >= cnt_x || pos2_x >= cnt_x) begin
                st_nxt = ST_BADIDX;
              end else if (pos_x == pos2_x) begin
                op        = OP_DOWN;
                op_pos    = pos_x;
                count_nxt = count_r - CW'(1);
              end else if (gap > IW'(1)) begin
                // strictly-between entries leave one place per cycle
                start_nxt = lo + IW'(1);
                left_nxt  = gap - IW'(1);
                state_nxt = S_SHIFT;
              end
            end
            ACT_READ: begin
              if (count_r == '0) st_nxt = ST_EMPTY;
              else if (pos_x >= cnt_x) st_nxt = ST_BADIDX;
              else rd_ok_nxt = 1'b1;
            end
            ACT_CLEAR: count_nxt = '0;
            default: ;
          endcase
        end
      end
      S_SHIFT: begin
        op        = OP_DOWN;
        op_pos    = start_r;
        count_nxt = count_r - CW'(1);
        left_nxt  = left_r - IW'(1);
        if (left_r == IW'(1)) state_nxt = S_REPORT;
      end
      S_REPORT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = st_r;
          out_rd_nxt     = rd_ok_r ? ext_out(cell_q[rd_idx_r]) : '0;
          out_count_nxt  = CNT_W'(count_r);
          out_empty_nxt  = (count_r == '0);
          out_first_nxt  = (count_r == '0) ? '0 : ext_out(cell_q[0]);
          out_last_nxt   = (count_r == '0) ? '0
                           : ext_out(cell_q[AW'(count_r - CW'(1))]);
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    start_r      <= start_nxt;
    left_r       <= left_nxt;
    rd_idx_r     <= rd_idx_nxt;
    rd_ok_r      <= rd_ok_nxt;
    st_r         <= st_nxt;
    out_status_r <= out_status_nxt;
    out_rd_r     <= out_rd_nxt;
    out_count_r  <= out_count_nxt;
    out_empty_r  <= out_empty_nxt;
    out_first_r  <= out_first_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.read_value  = out_rd_r;
  assign out_ch.count       = out_count_r;
  assign out_ch.is_empty    = out_empty_r;
  assign out_ch.first_value = out_first_r;
  assign out_ch.last_value  = out_last_r;

  `PLB_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= FULL_CNT, "count beyond depth")
  `PLB_ASSERT_NXT(a_acc_busy, clk, rst_n, in_acc, state_r != S_IDLE, "idle after accept")
  `PLB_ASSERT_IMP(a_shift_left, clk, rst_n, state_r == S_SHIFT, left_r != '0, "empty shift run")
  `PLB_ASSERT_NXT(a_shift_cnt, clk, rst_n, state_r == S_SHIFT,
                  count_r == $past(count_r) - CW'(1), "shift did not shrink list")
  `PLB_ASSERT_NXT(a_report_load, clk, rst_n, state_r == S_REPORT && !out_valid_r,
                  out_valid_r, "result not loaded")

endmodule

FILE: verif/plb_list_scoreboard.sv
`timescale 1ns / 1ps
// List buffer scoreboard: models the packed list and checks every result item
module plb_list_scoreboard
  import plb_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [ACT_W-1:0]   in_action,
  input  logic [POS_W-1:0]   in_position,
  input  logic [POS_W-1:0]   in_position_two,
  input  logic [VAL_W-1:0]   in_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [ST_W-1:0]    out_status,
  input  logic [VAL_W-1:0]   out_read_value,
  input  logic [CNT_W-1:0]   out_count,
  input  logic               out_is_empty,
  input  logic [VAL_W-1:0]   out_first_value,
  input  logic [VAL_W-1:0]   out_last_value,
  output int                 fail_count,
  output int                 owed
);

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [VAL_W-1:0] read_value;
    logic [CNT_W-1:0] count;
    logic             is_empty;
    logic [VAL_W-1:0] first_value;
    logic [VAL_W-1:0] last_value;
  } list_result_t;

  logic [VAL_W-1:0] list_words [DEPTH];
  int               words_held = 0;
  list_result_t     results_owed [$];
  int               bad_results = 0;
  int               results_seen = 0;
  int               owed_now = 0;

  assign fail_count = bad_results;
  assign owed       = owed_now;

  function automatic void open_slot(int at, logic [VAL_W-1:0] word);
    for (int i = words_held; i > at; i--) list_words[i] = list_words[i-1];
    list_words[at] = word;
    words_held++;
  endfunction

  function automatic void close_span(int start, int n);
    for (int i = start; i + n < words_held; i++) list_words[i] = list_words[i+n];
    words_held -= n;
  endfunction

  // Applies one action to the list and returns the result item it should give
  function automatic list_result_t apply_action(logic [ACT_W-1:0] act, int p, int p2,
                                                logic [VAL_W-1:0] word);
    list_result_t r;
    int lo, hi;
    r = '0;
    r.status = ST_OK;
    case (act)
      ACT_APPEND: begin
        if (words_held >= DEPTH) r.status = ST_FULL;
        else open_slot(words_held, word);
      end
      ACT_REMOVE: begin
        if (words_held == 0) r.status = ST_EMPTY;
        else words_held--;
      end
      ACT_INSERT: begin
        if (words_held == 0) p = 0;
        if (p > words_held) r.status = ST_BADIDX;
        else if (words_held >= DEPTH) r.status = ST_FULL;
        else open_slot(p, word);
      end
      ACT_ERASE: begin
        if (p >= words_held) r.status = ST_BADIDX;
        else close_span(p, 1);
      end
      ACT_ERASE_BT: begin
        if (p >= words_held || p2 >= words_held) begin
          r.status = ST_BADIDX;
        end else if (p == p2) begin
          close_span(p, 1);
        end else begin
          lo = (p < p2) ? p : p2;
          hi = (p < p2) ? p2 : p;
          // both bound entries survive
          if (hi - lo > 1) close_span(lo + 1, hi - lo - 1);
        end
      end
      ACT_READ: begin
        if (words_held == 0) r.status = ST_EMPTY;
        else if (p >= words_held) r.status = ST_BADIDX;
        else r.read_value = list_words[p];
      end
      ACT_CLEAR: words_held = 0;
      default: ;
    endcase
    r.count    = CNT_W'(words_held);
    r.is_empty = (words_held == 0);
    if (words_held != 0) begin
      r.first_value = list_words[0];
      r.last_value  = list_words[words_held-1];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    list_result_t want;
    list_result_t got;
    if (!rst_n) begin
      words_held = 0;
      results_owed.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = '{out_status, out_read_value, out_count, out_is_empty,
                out_first_value, out_last_value};
        if (results_owed.size() == 0) begin
          bad_results++;
          if (bad_results <= 10)
            $display("result %0d arrived with nothing owed", results_seen);
        end else begin
          want = results_owed.pop_front();
          if (got.status !== want.status || got.read_value !== want.read_value ||
              got.count !== want.count || got.is_empty !== want.is_empty ||
              got.first_value !== want.first_value ||
              got.last_value !== want.last_value) begin
            bad_results++;
            if (bad_results <= 10)
              $display("result %0d (want/got): status %0d/%0d read %0d/%0d ",
                       results_seen, want.status, got.status,
                       $signed(want.read_value), $signed(got.read_value),
                       "count %0d/%0d empty %0b/%0b first %0d/%0d last %0d/%0d",
                       want.count, got.count, want.is_empty, got.is_empty,
                       $signed(want.first_value), $signed(got.first_value),
                       $signed(want.last_value), $signed(got.last_value));
          end
        end
        results_seen++;
      end
      if (in_valid && in_ready)
        results_owed.insert(results_owed.size(),
                            apply_action(in_action, int'(in_position),
                                         int'(in_position_two), in_value));
    end
    owed_now = results_owed.size();
  end

endmodule

FILE: verif/tb_positional_list_buffer.sv
`timescale 1ns / 1ps
// List buffer testbench top: clock, reset, action items, back-pressure and verdict
module tb_positional_list_buffer;
  import plb_pkg::*;

  localparam logic [ACT_W-1:0] ACT_SPARE = 3'd7;   // unused code, must be a no-op
  localparam int LIST_DEPTH      = 64;
  localparam int QUIET_LIMIT     = 3000;
  localparam int DRAIN_CYCLES    = 80;
  localparam int ITEMS_PER_PHASE = 400;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  int   gap_pct   = 0;
  int   stall_pct = 0;
  int   len_guess = 0;
  int   quiet_cycles = 0;
  int   fail_count;
  int   owed;
  int   phase_gap   [4] = '{0, 76, 0, 30};
  int   phase_stall [4] = '{0, 0, 76, 30};

  plb_in_if  in_bus ();
  plb_out_if out_bus ();

  positional_list_buffer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  plb_list_scoreboard #(.DEPTH(LIST_DEPTH)) scoreboard (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_bus.valid),
    .in_ready        (in_bus.ready),
    .in_action       (in_bus.action),
    .in_position     (in_bus.position),
    .in_position_two (in_bus.position_two),
    .in_value        (in_bus.value),
    .out_valid       (out_bus.valid),
    .out_ready       (out_bus.ready),
    .out_status      (out_bus.status),
    .out_read_value  (out_bus.read_value),
    .out_count       (out_bus.count),
    .out_is_empty    (out_bus.is_empty),
    .out_first_value (out_bus.first_value),
    .out_last_value  (out_bus.last_value),
    .fail_count      (fail_count),
    .owed            (owed)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial out_bus.ready = 1'b0;
  always @(posedge clk) begin
    out_bus.ready <= rst_n && ($urandom_range(0, 99) >= stall_pct);
  end

  // Watchdog: too long without any item moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[positional_list_buffer] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Rough list length, only to steer positions towards useful values
  function automatic int next_len(int len, logic [ACT_W-1:0] a, int p, int p2);
    case (a)
      ACT_APPEND:   return (len < LIST_DEPTH) ? len + 1 : len;
      ACT_REMOVE:   return (len > 0) ? len - 1 : len;
      ACT_INSERT:   return (len < LIST_DEPTH && (len == 0 || p <= len)) ? len + 1 : len;
      ACT_ERASE:    return (p < len) ? len - 1 : len;
      ACT_ERASE_BT: begin
        if (p >= len || p2 >= len) return len;
        if (p == p2) return len - 1;
        return len - (((p > p2) ? p - p2 : p2 - p) - 1);
      end
      ACT_CLEAR:    return 0;
      default:      return len;
    endcase
  endfunction

  task automatic send(logic [ACT_W-1:0] a, logic [POS_W-1:0] p, logic [POS_W-1:0] p2,
                      logic [VAL_W-1:0] v);
    bit took;
    if ($urandom_range(0, 99) < gap_pct) begin
      in_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < gap_pct);
    end
    in_bus.valid        <= 1'b1;
    in_bus.action       <= a;
    in_bus.position     <= p;
    in_bus.position_two <= p2;
    in_bus.value        <= v;
    // ready is settled by mid-cycle; the item goes at the next rising edge
    do begin
      @(negedge clk);
      took = in_bus.ready;
      @(posedge clk);
    end while (!took);
    len_guess = next_len(len_guess, a, int'(p), int'(p2));
  endtask

  function automatic int pick_pos(int len);
    if ($urandom_range(0, 99) < 12) return $urandom_range(0, 127);
    return $urandom_range(0, len);
  endfunction

  task automatic send_random(bit grow);
    int r;
    int p;
    int p2;
    logic [ACT_W-1:0] a;
    logic [VAL_W-1:0] v;
    r = $urandom_range(0, 99);
    if (grow)
      a = (r < 50) ? ACT_APPEND : (r < 78) ? ACT_INSERT : (r < 84) ? ACT_REMOVE :
          (r < 88) ? ACT_ERASE : (r < 90) ? ACT_ERASE_BT : (r < 99) ? ACT_READ : ACT_SPARE;
    else
      a = (r < 12) ? ACT_APPEND : (r < 22) ? ACT_INSERT : (r < 44) ? ACT_REMOVE :
          (r < 64) ? ACT_ERASE : (r < 74) ? ACT_ERASE_BT : (r < 96) ? ACT_READ :
          (r < 98) ? ACT_CLEAR : ACT_SPARE;
    p  = pick_pos(len_guess);
    p2 = $urandom_range(0, 1) ? p + $urandom_range(0, 3) : pick_pos(len_guess);
    case ($urandom_range(0, 19))
      0:       v = 32'h8000_0000;
      1:       v = 32'h7fff_ffff;
      2:       v = 32'h0000_0000;
      3:       v = 32'hffff_ffff;
      default: v = $urandom();
    endcase
    send(a, POS_W'(p), POS_W'(p2), v);
  endtask

  initial begin
    in_bus.valid        = 1'b0;
    in_bus.action       = ACT_APPEND;
    in_bus.position     = '0;
    in_bus.position_two = '0;
    in_bus.value        = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty-list errors, insert edges, bounds, erase-between forms
    send(ACT_READ,     7'd0,   7'd0, 32'h0);
    send(ACT_REMOVE,   7'd0,   7'd0, 32'h0);
    send(ACT_ERASE,    7'd0,   7'd0, 32'h0);
    send(ACT_ERASE_BT, 7'd0,   7'd0, 32'h0);
    send(ACT_INSERT,   7'd90,  7'd0, 32'h8000_0000);  // empty list ignores position
    send(ACT_APPEND,   7'd0,   7'd0, 32'h7fff_ffff);
    send(ACT_INSERT,   7'd0,   7'd0, 32'h0000_0000);
    send(ACT_INSERT,   7'd3,   7'd0, 32'hffff_ffff);  // at count: appends
    send(ACT_INSERT,   7'd9,   7'd0, 32'h1234_5678);
    send(ACT_READ,     7'd4,   7'd0, 32'h0);
    send(ACT_READ,     7'd127, 7'd0, 32'h0);
    send(ACT_READ,     7'd1,   7'd0, 32'h0);
    send(ACT_READ,     7'd3,   7'd0, 32'h0);
    send(ACT_APPEND,   7'd0,   7'd0, 32'd5);
    send(ACT_APPEND,   7'd0,   7'd0, 32'd6);
    send(ACT_ERASE_BT, 7'd4,   7'd1, 32'h0);          // bounds reversed
    send(ACT_ERASE_BT, 7'd1,   7'd2, 32'h0);          // neighbours: nothing between
    send(ACT_ERASE_BT, 7'd2,   7'd2, 32'h0);
    send(ACT_ERASE_BT, 7'd0,   7'd9, 32'h0);
    send(ACT_ERASE,    7'd0,   7'd0, 32'h0);
    send(ACT_SPARE,    7'd127, 7'd127, 32'hffff_ffff);
    send(ACT_CLEAR,    7'd0,   7'd0, 32'h0);
    send(ACT_REMOVE,   7'd0,   7'd0, 32'h0);

    for (int ph = 0; ph < 4; ph++) begin
      gap_pct   = phase_gap[ph];
      stall_pct = phase_stall[ph];
      for (int i = 0; i < ITEMS_PER_PHASE; i++) send_random(((i / 100) % 2) == 0);
    end
    in_bus.valid <= 1'b0;

    do @(negedge clk); while (owed != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("[positional_list_buffer] OK");
    else $display("[positional_list_buffer] ERROR");
    $finish;
  end

endmodule
